>>> rtl/cia_pkg.sv
// cia_pkg: shared types, codes and constants for the checked integer ALU.
// No dependencies; used by every module under rtl.
package cia_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_WIDTH       = 3;
    localparam int STATUS_WIDTH   = 2;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [OP_WIDTH-1:0] OP_ADD = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_SUB = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_MUL = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_DIV = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_REM = 3'd4;

    localparam logic [STATUS_WIDTH-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_OVF  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_DIVZ = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_INV  = 2'd3;

    // class of work handed from front to back
    typedef enum logic [2:0] {
        CL_ADD,
        CL_SUB,
        CL_MUL,
        CL_DIV,
        CL_REM,
        CL_FIXED
    } cls_t;

endpackage

>>> rtl/cia_front.sv
// cia_front: accepts items, decodes the opcode and spots zero divisors and
// invalid codes. Depends on cia_pkg.
module cia_front #(
    parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [cia_pkg::OP_WIDTH-1:0]          op,
    input  logic signed [DATA_WIDTH-1:0]          operand_a,
    input  logic signed [DATA_WIDTH-1:0]          operand_b,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output cia_pkg::cls_t                         out_cls,
    output logic [cia_pkg::STATUS_WIDTH-1:0]      out_status,
    output logic [DATA_WIDTH-1:0]                 out_a,
    output logic [DATA_WIDTH-1:0]                 out_b
);

    logic                                 valid_reg;
    cia_pkg::cls_t                        cls_reg, cls_next;
    logic [cia_pkg::STATUS_WIDTH-1:0]     st_reg, st_next;
    logic [DATA_WIDTH-1:0]                a_reg, b_reg;

    assign in_ready = !valid_reg || out_ready;

    // opcode decode and early status
    always_comb
    begin
        cls_next = cia_pkg::CL_FIXED;
        st_next  = cia_pkg::ST_OK;
        unique case (op)
            cia_pkg::OP_ADD: cls_next = cia_pkg::CL_ADD;
            cia_pkg::OP_SUB: cls_next = cia_pkg::CL_SUB;
            cia_pkg::OP_MUL: cls_next = cia_pkg::CL_MUL;
            cia_pkg::OP_DIV, cia_pkg::OP_REM:
            begin
                if (operand_b == '0)
                    st_next = cia_pkg::ST_DIVZ;
                else
                    cls_next = (op == cia_pkg::OP_DIV) ? cia_pkg::CL_DIV : cia_pkg::CL_REM;
            end
            default: st_next = cia_pkg::ST_INV;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cls_reg <= cls_next;
            st_reg  <= st_next;
            a_reg   <= operand_a;
            b_reg   <= operand_b;
        end
    end

    assign out_valid  = valid_reg;
    assign out_cls    = cls_reg;
    assign out_status = st_reg;
    assign out_a      = a_reg;
    assign out_b      = b_reg;

endmodule

>>> rtl/cia_queue.sv
// cia_queue: short FIFO between front and back parts.
// Depends on cia_pkg.
module cia_queue #(
    parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH      = cia_pkg::QUEUE_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_valid,
    output logic                                  wr_ready,
    input  cia_pkg::cls_t                         wr_cls,
    input  logic [cia_pkg::STATUS_WIDTH-1:0]      wr_status,
    input  logic [DATA_WIDTH-1:0]                 wr_a,
    input  logic [DATA_WIDTH-1:0]                 wr_b,
    output logic                                  rd_valid,
    input  logic                                  rd_ready,
    output cia_pkg::cls_t                         rd_cls,
    output logic [cia_pkg::STATUS_WIDTH-1:0]      rd_status,
    output logic [DATA_WIDTH-1:0]                 rd_a,
    output logic [DATA_WIDTH-1:0]                 rd_b
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cia_pkg::cls_t                    cls_mem [DEPTH];
    logic [cia_pkg::STATUS_WIDTH-1:0] st_mem  [DEPTH];
    logic [DATA_WIDTH-1:0]            a_mem   [DEPTH];
    logic [DATA_WIDTH-1:0]            b_mem   [DEPTH];
    logic [AW-1:0]                    wp_reg, rp_reg;
    logic [AW:0]                      cnt_reg;
    logic                             wr_go, rd_go;

    assign wr_ready = cnt_reg != (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign wr_go    = wr_valid && wr_ready;
    assign rd_go    = rd_valid && rd_ready;

    // pointers wrap at the depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_go)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd_go)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            if (wr_go && !rd_go)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd_go && !wr_go)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_go)
        begin
            cls_mem[wp_reg] <= wr_cls;
            st_mem[wp_reg]  <= wr_status;
            a_mem[wp_reg]   <= wr_a;
            b_mem[wp_reg]   <= wr_b;
        end
    end

    assign rd_cls    = cls_mem[rp_reg];
    assign rd_status = st_mem[rp_reg];
    assign rd_a      = a_mem[rp_reg];
    assign rd_b      = b_mem[rp_reg];

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue count past depth");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_go && !rd_go) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a write");
    a_empty_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> wp_reg == rp_reg)
        else $error("empty queue with pointers apart");
`endif

endmodule

>>> rtl/cia_back.sv
// cia_back: pipelined execute part: add/sub, multiply with overflow check,
// restoring divider one quotient bit per stage. Depends on cia_pkg.
module cia_back #(
    parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  cia_pkg::cls_t                         in_cls,
    input  logic [cia_pkg::STATUS_WIDTH-1:0]      in_status,
    input  logic [DATA_WIDTH-1:0]                 in_a,
    input  logic [DATA_WIDTH-1:0]                 in_b,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [DATA_WIDTH-1:0]                 out_value,
    output logic [cia_pkg::STATUS_WIDTH-1:0]      out_status
);

    localparam int W  = DATA_WIDTH;
    localparam int NS = W + 2;   // stage 0 setup, W divide steps, final stage
    localparam int HW = (W + 1) / 2;

    // per-stage pipeline registers
    logic                         v_reg   [NS];
    cia_pkg::cls_t                cls_reg [NS];
    logic [cia_pkg::STATUS_WIDTH-1:0] st_reg [NS];
    logic [W-1:0]                 rem_reg [NS];
    logic [W-1:0]                 quo_reg [NS];
    logic [W-1:0]                 div_reg [NS];
    logic                         na_reg  [NS];
    logic                         nb_reg  [NS];
    logic [2*W-1:0]               prod_reg [NS];
    logic [W-1:0]                 res_reg [NS];

    logic                         adv;
    logic [W-1:0]                 ma, mb, sum, dif;
    logic                         na, nb;
    logic                         add_ovf, sub_ovf;
    logic [W-1:0]                 res0;
    logic [cia_pkg::STATUS_WIDTH-1:0] st0;

    // magnitude of a survives in stage 1 only through the quotient shift,
    // so keep it beside the pipe for the multiply's second half
    logic [W-1:0]                 magn_a_reg;

    // whole pipe moves together; a stalled output freezes it
    assign adv      = !v_reg[NS-1] || out_ready;
    assign in_ready = adv;

    assign na  = in_a[W-1];
    assign nb  = in_b[W-1];
    assign ma  = na ? (W'(0) - in_a) : in_a;
    assign mb  = nb ? (W'(0) - in_b) : in_b;
    assign sum = in_a + in_b;
    assign dif = in_a - in_b;
    assign add_ovf = (na == nb) && (sum[W-1] != na);
    assign sub_ovf = (na != nb) && (dif[W-1] != na);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                v_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    // stage 0 result for add/sub
    always_comb
    begin
        res0 = '0;
        st0  = in_status;
        case (in_cls)
            cia_pkg::CL_ADD:
            begin
                res0 = sum;
                if (add_ovf)
                    st0 = cia_pkg::ST_OVF;
            end
            cia_pkg::CL_SUB:
            begin
                res0 = dif;
                if (sub_ovf)
                    st0 = cia_pkg::ST_OVF;
            end
            default: ;
        endcase
    end

    // stage 0: add/sub result, operand magnitudes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cls_reg[0]  <= in_cls;
            st_reg[0]   <= st0;
            na_reg[0]   <= na;
            nb_reg[0]   <= nb;
            rem_reg[0]  <= '0;
            quo_reg[0]  <= ma;
            div_reg[0]  <= mb;
            prod_reg[0] <= '0;
            res_reg[0]  <= res0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            magn_a_reg <= quo_reg[0];
    end

    // stages 1..W: one restoring divide step each; multiply split in halves
    for (genvar s = 1; s <= W; s++)
    begin : g_step
        logic [W:0]     trial;
        logic [W-1:0]   rsh;
        logic           take_sub;
        logic [2*W-1:0] prod_nx;

        assign rsh      = {rem_reg[s-1][W-2:0], quo_reg[s-1][W-1]};
        assign trial    = {1'b0, rsh} - {1'b0, div_reg[s-1]};
        assign take_sub = rem_reg[s-1][W-1] || !trial[W];

        // multiplier: low half of mb at step 1, high half at step 2
        if (s == 1)
        begin : g_mlo
            logic [W+HW-1:0] part;
            assign part    = quo_reg[0] * div_reg[0][HW-1:0];
            assign prod_nx = (2*W)'(part);
        end
        else if (s == 2)
        begin : g_mhi
            logic [2*W-HW-1:0] part;
            assign part    = magn_a_reg * div_reg[1][W-1:HW];
            assign prod_nx = prod_reg[1] + {part, {HW{1'b0}}};
        end
        else
        begin : g_mpass
            assign prod_nx = prod_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cls_reg[s]  <= cls_reg[s-1];
                st_reg[s]   <= st_reg[s-1];
                na_reg[s]   <= na_reg[s-1];
                nb_reg[s]   <= nb_reg[s-1];
                div_reg[s]  <= div_reg[s-1];
                res_reg[s]  <= res_reg[s-1];
                prod_reg[s] <= prod_nx;
                rem_reg[s]  <= take_sub ? trial[W-1:0] : rsh;
                quo_reg[s]  <= {quo_reg[s-1][W-2:0], take_sub};
            end
        end
    end

    // final stage: sign fix-up, overflow checks, zero on error
    logic [W-1:0] q_fin, r_fin, p_lo, mres, dres;
    logic [W-1:0] half;
    logic         neg, p_big, q_big;
    logic [cia_pkg::STATUS_WIDTH-1:0] st_fin;
    logic [W-1:0] v_fin;

    assign half  = {1'b1, {(W-1){1'b0}}};
    assign neg   = na_reg[NS-2] != nb_reg[NS-2];
    assign q_fin = quo_reg[NS-2];
    assign r_fin = rem_reg[NS-2];
    assign p_lo  = prod_reg[NS-2][W-1:0];
    assign p_big = (prod_reg[NS-2][2*W-1:W] != '0)
                   || (neg ? (p_lo > half) : p_lo[W-1]);
    assign q_big = !neg && q_fin[W-1];
    assign mres  = neg ? (W'(0) - p_lo) : p_lo;
    assign dres  = neg ? (W'(0) - q_fin) : q_fin;

    always_comb
    begin
        st_fin = st_reg[NS-2];
        v_fin  = res_reg[NS-2];
        case (cls_reg[NS-2])
            cia_pkg::CL_MUL:
            begin
                v_fin = mres;
                if (p_big)
                    st_fin = cia_pkg::ST_OVF;
            end
            cia_pkg::CL_DIV:
            begin
                v_fin = dres;
                if (q_big)
                    st_fin = cia_pkg::ST_OVF;
            end
            cia_pkg::CL_REM:
                v_fin = na_reg[NS-2] ? (W'(0) - r_fin) : r_fin;
            default: ;
        endcase
        if (st_fin != cia_pkg::ST_OK)
            v_fin = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[NS-1]  <= st_fin;
            res_reg[NS-1] <= v_fin;
        end
    end

    assign out_valid  = v_reg[NS-1];
    assign out_value  = res_reg[NS-1];
    assign out_status = st_reg[NS-1];

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_value) && $stable(out_status))
        else $error("result changed while stalled");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status != cia_pkg::ST_OK) |-> out_value == '0)
        else $error("error result not zero");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && v_reg[NS-2]) |=> v_reg[NS-1])
        else $error("item lost in last stage");
`endif

endmodule

>>> rtl/cia_outq.sv
// cia_outq: result skid register that parts back end from the receiver.
// Depends on cia_pkg.
module cia_outq #(
    parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [DATA_WIDTH-1:0]                 in_value,
    input  logic [cia_pkg::STATUS_WIDTH-1:0]      in_status,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [DATA_WIDTH-1:0]                 value,
    output logic [cia_pkg::STATUS_WIDTH-1:0]      status
);

    logic                             full_reg, skid_reg;
    logic [DATA_WIDTH-1:0]            val_reg, sval_reg;
    logic [cia_pkg::STATUS_WIDTH-1:0] st_reg, sst_reg;
    logic                             take, give;

    assign in_ready = !skid_reg;
    assign take     = in_valid && !skid_reg;
    assign give     = full_reg && pop;

    // main register plus one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            skid_reg <= 1'b0;
        end
        else
        begin
            if (give)
                full_reg <= skid_reg || take;
            else if (take)
                full_reg <= 1'b1;
            if (give)
                skid_reg <= 1'b0;
            else if (take && full_reg)
                skid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (give && skid_reg)
        begin
            val_reg <= sval_reg;
            st_reg  <= sst_reg;
        end
        else if (take && (give || !full_reg))
        begin
            val_reg <= in_value;
            st_reg  <= in_status;
        end
        if (take && full_reg && !give)
        begin
            sval_reg <= in_value;
            sst_reg  <= in_status;
        end
    end

    assign empty  = !full_reg;
    assign value  = val_reg;
    assign status = st_reg;

endmodule

>>> rtl/checked_int_alu.sv
// checked_int_alu: top level of the overflow-checked signed ALU.
// Depends on cia_pkg, cia_front, cia_queue, cia_back, cia_outq.
//
// Usage:
//   Input channel: an item (op, operand_a, operand_b) transfers at a clock
//   edge with push high and full low. Result channel: while empty is low the
//   oldest result (value, status) is on the ports; it transfers on pop.
//   Ops: add, subtract, multiply, divide, remainder; status ok, overflow,
//   divide by zero or invalid opcode, value zero unless ok.
//   Path: the front register loads at the transfer edge, then the queue,
//   the back pipe of DATA_WIDTH + 2 stages (a setup stage, a restoring
//   divide step in each stage between, a final stage) and the output
//   register; from there the result is on the ports and can be popped.
//   Throughput: one item per cycle while the receiver keeps popping; every
//   pipe stage takes a new item each cycle while it is not stalled.
//   Reset: all pipes and queues empty, full low, empty high.
//   Receiver stall: the output register and its skid entry fill, the back
//   pipe freezes, the queue and front register fill and then full rises.
module checked_int_alu #(
    parameter int DATA_WIDTH = cia_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [cia_pkg::OP_WIDTH-1:0]          op,
    input  logic signed [DATA_WIDTH-1:0]          operand_a,
    input  logic signed [DATA_WIDTH-1:0]          operand_b,
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [DATA_WIDTH-1:0]          value,
    output logic [cia_pkg::STATUS_WIDTH-1:0]      status
);

    logic                             f_valid, f_ready, q_valid, q_ready;
    logic                             b_valid, b_ready, in_ready;
    cia_pkg::cls_t                    f_cls, q_cls;
    logic [cia_pkg::STATUS_WIDTH-1:0] f_st, q_st, b_st;
    logic [DATA_WIDTH-1:0]            f_a, f_b, q_a, q_b, b_val, o_val;

    assign full = !in_ready;

    cia_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(push), .in_ready(in_ready),
        .op(op), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(f_valid), .out_ready(f_ready),
        .out_cls(f_cls), .out_status(f_st), .out_a(f_a), .out_b(f_b)
    );

    cia_queue #(.DATA_WIDTH(DATA_WIDTH), .DEPTH(cia_pkg::QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready),
        .wr_cls(f_cls), .wr_status(f_st), .wr_a(f_a), .wr_b(f_b),
        .rd_valid(q_valid), .rd_ready(q_ready),
        .rd_cls(q_cls), .rd_status(q_st), .rd_a(q_a), .rd_b(q_b)
    );

    cia_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready),
        .in_cls(q_cls), .in_status(q_st), .in_a(q_a), .in_b(q_b),
        .out_valid(b_valid), .out_ready(b_ready),
        .out_value(b_val), .out_status(b_st)
    );

    cia_outq #(.DATA_WIDTH(DATA_WIDTH)) u_outq (
        .clk(clk), .rst_n(rst_n),
        .in_valid(b_valid), .in_ready(b_ready),
        .in_value(b_val), .in_status(b_st),
        .empty(empty), .pop(pop),
        .value(o_val), .status(status)
    );

    assign value = o_val;

endmodule
